/* hw/rtl/utf8f_pkg.sv */
// Shared types, constants and the Latin-1 accent table for the UTF-8 folder.
`timescale 1ns / 1ps

package utf8f_pkg;

  localparam int ByteW = 8;
  localparam int CharW = 7;
  localparam int SkipW = 2;

  localparam logic [ByteW-1:0] AsciiUpperA = 8'h41;
  localparam logic [ByteW-1:0] AsciiUpperZ = 8'h5A;
  localparam logic [ByteW-1:0] CaseBit     = 8'h20;
  localparam logic [ByteW-1:0] AsciiLimit  = 8'h80;
  localparam logic [ByteW-1:0] AccentLead  = 8'hC3;
  localparam logic [ByteW-1:0] ContLow     = 8'h80;
  localparam logic [ByteW-1:0] ContHigh    = 8'hBF;
  localparam logic [ByteW-1:0] UpperLast   = 8'h9E;
  localparam logic [ByteW-1:0] SharpS      = 8'h9F;
  localparam logic [ByteW-1:0] Lead2Low    = 8'hC2;
  localparam logic [ByteW-1:0] Lead2High   = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Low    = 8'hE0;
  localparam logic [ByteW-1:0] Lead3High   = 8'hEF;
  localparam logic [ByteW-1:0] Lead4Low    = 8'hF0;
  localparam logic [ByteW-1:0] Lead4High   = 8'hF4;

  localparam logic [CharW-1:0] NoChar = 7'h00;

  // Sequence tracking carried from one byte to the next.
  typedef struct packed {
    logic [SkipW-1:0] skip_remaining;
    logic             accent_pending;
  } fold_state_t;

  // One result beat.
  typedef struct packed {
    logic             char_valid;
    logic [CharW-1:0] out_char;
    logic             end_of_string;
  } fold_result_t;

  // Second byte of a 0xC3 pair to its lowercase ASCII base, or NoChar.
  function automatic logic [CharW-1:0] accent_base(logic [ByteW-1:0] lo);
    logic [ByteW-1:0] f;
    logic [CharW-1:0] r;
    f = lo;
    r = NoChar;
    if (lo >= ContLow && lo <= ContHigh) begin
      if (lo <= UpperLast) begin
        f = lo | CaseBit;
      end
      priority if (f >= 8'hA0 && f <= 8'hA5) r = 7'h61;  // a
      else if (f == 8'hA7)                   r = 7'h63;  // c
      else if (f >= 8'hA8 && f <= 8'hAB)     r = 7'h65;  // e
      else if (f >= 8'hAC && f <= 8'hAF)     r = 7'h69;  // i
      else if (f == 8'hB1)                   r = 7'h6E;  // n
      else if (f >= 8'hB2 && f <= 8'hB6)     r = 7'h6F;  // o
      else if (f >= 8'hB9 && f <= 8'hBC)     r = 7'h75;  // u
      else if (f == 8'hBD || f == 8'hBF)     r = 7'h79;  // y
      else if (f == SharpS)                  r = 7'h73;  // s
      else                                   r = NoChar;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/utf8f_fold.sv */
// Per-byte folding logic: result of one byte and the sequence state after it.
`timescale 1ns / 1ps

module utf8f_fold (
  input  logic [utf8f_pkg::ByteW-1:0] byte_i,
  input  logic                        last_i,
  input  utf8f_pkg::fold_state_t      state_i,
  output utf8f_pkg::fold_result_t     result_o,
  output utf8f_pkg::fold_state_t      state_o
);
  import utf8f_pkg::*;

  logic             valid;
  logic [CharW-1:0] ch;
  fold_state_t      st;

  always_comb begin
    valid = 1'b0;
    ch    = NoChar;
    st    = state_i;
    priority if (state_i.skip_remaining != '0) begin
      if (state_i.accent_pending) begin
        ch    = accent_base(byte_i);
        valid = (ch != NoChar);
      end
      st.accent_pending = 1'b0;
      st.skip_remaining = state_i.skip_remaining - SkipW'(1);
    end else if (byte_i >= AsciiUpperA && byte_i <= AsciiUpperZ) begin
      valid = 1'b1;
      ch    = CharW'(byte_i + CaseBit);
    end else if (byte_i < AsciiLimit) begin
      valid = 1'b1;
      ch    = byte_i[CharW-1:0];
    end else begin
      // A lead byte sets how many continuation bytes to drop.
      priority if (byte_i >= Lead2Low && byte_i <= Lead2High) st.skip_remaining = 2'd1;
      else if (byte_i >= Lead3Low && byte_i <= Lead3High)     st.skip_remaining = 2'd2;
      else if (byte_i >= Lead4Low && byte_i <= Lead4High)     st.skip_remaining = 2'd3;
      else                                                    st.skip_remaining = 2'd0;
      st.accent_pending = (byte_i == AccentLead);
    end
    // The end of a string always leaves the next one starting clean.
    if (last_i) begin
      st = '0;
    end
  end

  assign result_o = '{char_valid: valid, out_char: ch, end_of_string: last_i};
  assign state_o  = st;

endmodule

/* hw/rtl/utf8_latin1_accent_fold.sv */
// Top level of the UTF-8 to lowercase ASCII folder with Latin-1 accent removal.
`timescale 1ns / 1ps

// Takes one UTF-8 byte per beat and gives exactly one result beat per input
// beat: ASCII letters come out lowercase, other ASCII passes, multi-byte
// sequences are dropped except that a 0xC3 pair yields the base letter of an
// accented Latin-1 character when it has one. A byte is held in an input
// register and folded into an output register, and one byte can be taken
// every cycle while the output is not stalled; the input stage keeps
// accepting while a finished result waits, and stalls only when both stages
// are full. The sequence state clears after a byte marked last.

module utf8_latin1_accent_fold (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [utf8f_pkg::ByteW-1:0] in_byte,
  input  logic                        in_is_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_char_valid,
  output logic [utf8f_pkg::CharW-1:0] out_char,
  output logic                        out_end_of_string
);
  import utf8f_pkg::*;

  logic             in_valid_r, in_valid_nxt;
  logic [ByteW-1:0] in_byte_r;
  logic             in_last_r;
  logic             out_valid_r, out_valid_nxt;
  fold_result_t     result_r;
  fold_state_t      state_r, state_nxt;
  fold_result_t     fold_res;
  fold_state_t      fold_st;
  logic             out_free;
  logic             advance;
  logic             in_take;

  utf8f_fold u_fold (
    .byte_i   (in_byte_r),
    .last_i   (in_last_r),
    .state_i  (state_r),
    .result_o (fold_res),
    .state_o  (fold_st)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt  = in_take || (in_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
    state_nxt     = advance ? fold_st : state_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_byte;
      in_last_r <= in_is_last;
    end
    if (advance) begin
      result_r <= fold_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_char_valid    = result_r.char_valid;
  assign out_char          = result_r.out_char;
  assign out_end_of_string = result_r.end_of_string;

  // An accent pair always has exactly its second byte left to skip.
  a_accent_skip: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.accent_pending |-> state_r.skip_remaining == 2'd1)
    else $error("accent pending without a single byte left to skip");

  // The byte that closes a string leaves no sequence state behind.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_last_r) |=> state_r == '0)
    else $error("sequence state survived the end of a string");

  // A dropped character always carries a zero code.
  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_char_valid) |-> (out_char == NoChar))
    else $error("dropped character carries a nonzero code");

  // A beat waiting in the input register moves on as soon as the output frees.
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("input beat was not moved into an empty output register");

endmodule

/* test/tb_utf8_latin1_accent_fold.sv */
// Self-checking testbench for the UTF-8 to lowercase ASCII accent folder.
`timescale 1ns / 1ps

module tb_utf8_latin1_accent_fold;

  import utf8f_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             last;
    logic             drain;
  } beat_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] in_byte = '0;
  logic             in_is_last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_char_valid;
  logic [CharW-1:0] out_char;
  logic             out_end_of_string;

  beat_t        pending_beats[$];
  fold_result_t expected_chars[$];
  logic [SkipW-1:0] seq_skip = '0;
  logic             seq_accent = 1'b0;
  logic             stim_ready = 1'b0;
  int               send_gap = 0;
  int               stall_left = 0;
  int unsigned      errors = 0;

  utf8_latin1_accent_fold dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .in_is_last        (in_is_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_char_valid    (out_char_valid),
    .out_char          (out_char),
    .out_end_of_string (out_end_of_string)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Base letter of an accented Latin-1 character, given the byte after 0xC3.
  function automatic logic [CharW-1:0] latin1_letter(logic [ByteW-1:0] lo);
    logic [ByteW-1:0] f;
    logic [ByteW-1:0] letter;
    letter = 8'h00;
    f = lo;
    if (lo >= ContLow && lo <= ContHigh) begin
      // Capitals sit 0x20 below their lowercase forms, except for sharp s.
      if (lo <= UpperLast) f = lo | CaseBit;
      if (f >= 8'hA0 && f <= 8'hA5) letter = "a";
      else if (f == 8'hA7) letter = "c";
      else if (f >= 8'hA8 && f <= 8'hAB) letter = "e";
      else if (f >= 8'hAC && f <= 8'hAF) letter = "i";
      else if (f == 8'hB1) letter = "n";
      else if (f >= 8'hB2 && f <= 8'hB6) letter = "o";
      else if (f >= 8'hB9 && f <= 8'hBC) letter = "u";
      else if (f == 8'hBD || f == 8'hBF) letter = "y";
      else if (f == SharpS) letter = "s";
    end
    return letter[CharW-1:0];
  endfunction

  // Folds one byte and advances the sequence state.
  function automatic fold_result_t fold_next(logic [ByteW-1:0] b, logic last);
    fold_result_t r;
    logic [ByteW-1:0] c;
    r = '0;
    r.end_of_string = last;
    c = b;
    if (seq_skip != 0) begin
      if (seq_accent) begin
        r.out_char = latin1_letter(b);
        r.char_valid = (r.out_char != NoChar);
      end
      seq_accent = 1'b0;
      seq_skip = seq_skip - SkipW'(1);
    end else if (b < AsciiLimit) begin
      if (b >= AsciiUpperA && b <= AsciiUpperZ) c = b | CaseBit;
      r.char_valid = 1'b1;
      r.out_char = c[CharW-1:0];
    end else begin
      if (b >= Lead2Low && b <= Lead2High) seq_skip = 2'd1;
      else if (b >= Lead3Low && b <= Lead3High) seq_skip = 2'd2;
      else if (b >= Lead4Low && b <= Lead4High) seq_skip = 2'd3;
      else seq_skip = 2'd0;
      seq_accent = (b == AccentLead);
    end
    if (last) begin
      seq_skip = '0;
      seq_accent = 1'b0;
    end
    return r;
  endfunction

  function automatic logic quiet_tail();
    return stim_ready && pending_beats.size() < 150;
  endfunction

  task automatic push_beat(logic [ByteW-1:0] b, logic last);
    beat_t t;
    t.b = b;
    t.last = last;
    t.drain = 1'b0;
    pending_beats.push_back(t);
  endtask

  task automatic push_drain();
    beat_t t;
    t = '0;
    t.drain = 1'b1;
    pending_beats.push_back(t);
  endtask

  function automatic logic [ByteW-1:0] cont_byte();
    if ($urandom_range(0, 7) == 0) return ByteW'($urandom_range(0, 255));
    return ByteW'($urandom_range(8'h80, 8'hBF));
  endfunction

  // Driver: presents the next pending beat once the current one is taken.
  always @(posedge clk) begin
    beat_t head;
    logic  fire;
    fire = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) expected_chars.push_back(fold_next(in_byte, in_is_last));
      if (fire || !in_valid) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_beats[0].drain) begin
          // Hold off until the block has delivered everything in flight.
          in_valid <= 1'b0;
          if (expected_chars.size() == 0) void'(pending_beats.pop_front());
        end else begin
          head = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_byte <= head.b;
          in_is_last <= head.last;
          if (!quiet_tail() && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 14);
        end
      end
    end
  end

  // Monitor: checks each result beat and drives random stall bursts.
  always @(posedge clk) begin
    fold_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $error("result beat with no byte waiting for it");
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char_valid !== want.char_valid) begin
            $error("char_valid: expected %0b, got %0b", want.char_valid, out_char_valid);
            errors++;
          end
          if (out_char !== want.out_char) begin
            $error("out_char: expected 0x%02h, got 0x%02h", want.out_char, out_char);
            errors++;
          end
          if (out_end_of_string !== want.end_of_string) begin
            $error("end_of_string: expected %0b, got %0b", want.end_of_string,
                   out_end_of_string);
            errors++;
          end
        end
      end
      if (!quiet_tail() && stall_left == 0 && $urandom_range(0, 19) == 0)
        stall_left = $urandom_range(1, 14);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [ByteW-1:0] str[$];
    int unsigned      total;
    int unsigned      n;
    int unsigned      kind;
    int unsigned      keep;
    logic             drained_mid;
    drained_mid = 1'b0;

    // Plain ASCII at the edges of the capital range and of the byte range.
    push_beat("A", 1'b0);
    push_beat("Z", 1'b0);
    push_beat("@", 1'b0);
    push_beat("[", 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'h7F, 1'b0);
    // Accented pairs: capital A grave, y diaeresis, sharp s, ae with no base.
    push_beat(AccentLead, 1'b0);
    push_beat(8'h80, 1'b0);
    push_beat(AccentLead, 1'b0);
    push_beat(8'hBF, 1'b0);
    push_beat(AccentLead, 1'b0);
    push_beat(SharpS, 1'b0);
    push_beat(AccentLead, 1'b0);
    push_beat(8'hA6, 1'b0);
    // A pair whose second byte is not a continuation byte ends the string.
    push_beat(AccentLead, 1'b0);
    push_beat("Z", 1'b1);
    // Stray bytes where a lead is due.
    push_beat(8'h80, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hC1, 1'b0);
    // A three-byte sequence, then a four-byte one cut short by the end mark.
    push_beat(8'hE2, 1'b0);
    push_beat(8'h82, 1'b0);
    push_beat(8'hAC, 1'b0);
    push_beat(8'hF0, 1'b0);
    push_beat(8'h9F, 1'b1);
    push_beat("Q", 1'b1);
    push_drain();
    total = 25;

    while (total < 1725) begin
      str.delete();
      n = $urandom_range(1, 12);
      repeat (n) begin
        kind = $urandom_range(0, 15);
        if (kind < 6) begin
          str.push_back(ByteW'($urandom_range(0, 127)));
        end else if (kind < 8) begin
          str.push_back(AsciiUpperA + ByteW'($urandom_range(0, 25)));
        end else if (kind < 11) begin
          str.push_back(AccentLead);
          if (kind == 10) str.push_back(ByteW'($urandom_range(0, 255)));
          else str.push_back(ByteW'($urandom_range(8'h80, 8'hBF)));
        end else if (kind == 11) begin
          str.push_back(ByteW'($urandom_range(Lead2Low, Lead2High)));
          str.push_back(cont_byte());
        end else if (kind == 12) begin
          str.push_back(ByteW'($urandom_range(Lead3Low, Lead3High)));
          repeat (2) str.push_back(cont_byte());
        end else if (kind == 13) begin
          str.push_back(ByteW'($urandom_range(Lead4Low, Lead4High)));
          repeat (3) str.push_back(cont_byte());
        end else begin
          str.push_back(ByteW'($urandom_range(0, 255)));
        end
      end
      // Now and then the string ends in the middle of whatever comes next.
      if ($urandom_range(0, 7) == 0) begin
        keep = $urandom_range(1, str.size());
        while (str.size() > keep) void'(str.pop_back());
      end
      for (int i = 0; i < str.size(); i++) push_beat(str[i], i == str.size() - 1);
      total += str.size();
      if (!drained_mid && total > 900) begin
        push_drain();
        drained_mid = 1'b1;
      end
    end
    stim_ready = 1'b1;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_utf8_latin1_accent_fold OK");
    end else begin
      $display("tb_utf8_latin1_accent_fold NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_utf8_latin1_accent_fold NOT OK");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/utf8f_pkg.sv
hw/rtl/utf8f_fold.sv
hw/rtl/utf8_latin1_accent_fold.sv
test/tb_utf8_latin1_accent_fold.sv
